[rtl/core/pfcab_pkg.sv]
// Shared types, register indexes and divide helpers for the pixel format converter.
package pfcab_pkg;

   localparam logic [2:0] FMT_GRAY8  = 3'd0;
   localparam logic [2:0] FMT_GRAY16 = 3'd1;
   localparam logic [2:0] FMT_RGB24  = 3'd2;
   localparam logic [2:0] FMT_RGB48  = 3'd3;
   localparam logic [2:0] FMT_RGBA32 = 3'd4;
   localparam logic [2:0] FMT_RGBA64 = 3'd5;

   localparam logic [2:0] REG_OUT_FORMAT        = 3'd0;
   localparam logic [2:0] REG_BLEND_ENABLE      = 3'd1;
   localparam logic [2:0] REG_BACKGROUND_NARROW = 3'd2;
   localparam logic [2:0] REG_BACKGROUND_WIDE   = 3'd3;
   localparam logic [2:0] REG_RED_SLOT          = 3'd4;
   localparam logic [2:0] REG_GREEN_SLOT        = 3'd5;
   localparam logic [2:0] REG_BLUE_SLOT         = 3'd6;
   localparam logic [2:0] REG_ALPHA_SLOT        = 3'd7;

   localparam logic [2:0] NO_ALPHA_SLOT = 3'd4;
   localparam int         CSR_DATA_W    = 48;

   typedef struct packed {
      logic        wide_components;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] alpha_in;
   } pfcab_req_type;

   typedef struct packed {
      logic [15:0] slot0;
      logic [15:0] slot1;
      logic [15:0] slot2;
      logic [15:0] slot3;
      logic [3:0]  slot_written;
   } pfcab_rsp_type;

   // one classified pixel, as it waits between front and back
   typedef struct packed {
      logic             fmt_valid;
      logic             gray;
      logic             blend;
      logic             wide_in;
      logic             narrow_out;
      logic             keep_alpha;
      logic [15:0]      alpha;
      logic [15:0]      inv_alpha;
      logic [2:0][15:0] cw;
      logic [2:0][15:0] bg;
      logic [15:0]      alpha_val;
      logic [1:0]       red_slot;
      logic [1:0]       green_slot;
      logic [1:0]       blue_slot;
      logic [1:0]       alpha_slot;
   } pfcab_job_type;

   // floor(x/257) for a 16-bit value: x = 257*hi + (lo - hi)
   function automatic logic [15:0] div257(input logic [15:0] x);
      logic [7:0] q0;
      logic [7:0] q;
      q0 = x[15:8];
      q  = (x[7:0] < q0) ? q0 - 8'd1 : q0;
      return {8'd0, q};
   endfunction

   // floor(x/max), max 65535 when wide else 255; folds the high part back twice
   function automatic logic [15:0] div_by_max(input logic [31:0] x, input logic wide);
      logic [16:0] w_r1;
      logic [16:0] w_r2;
      logic [17:0] w_q;
      logic [16:0] n_r1;
      logic [9:0]  n_r2;
      logic [17:0] n_q;
      w_r1 = {1'b0, x[15:0]} + {1'b0, x[31:16]};
      w_r2 = {1'b0, w_r1[15:0]} + {16'd0, w_r1[16]};
      w_q  = {2'b0, x[31:16]} + {17'd0, w_r1[16]}
           + {17'd0, (w_r2 >= 17'd65535)} + {17'd0, (w_r2 >= 17'd131070)};
      n_r1 = {9'd0, x[7:0]} + {1'b0, x[23:8]};
      n_r2 = {2'b0, n_r1[7:0]} + {1'b0, n_r1[16:8]};
      n_q  = {2'b0, x[23:8]} + {9'd0, n_r1[16:8]}
           + {17'd0, (n_r2 >= 10'd255)} + {17'd0, (n_r2 >= 10'd510)};
      return wide ? w_q[15:0] : n_q[15:0];
   endfunction

endpackage

[rtl/core/pfcab_front.sv]
// Front end: configuration registers, pixel intake and classification.
module pfcab_front import pfcab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  start,
   input  pfcab_req_type         req_data,
   output logic                  busy,
   output logic                  job_valid,
   output pfcab_job_type         job,
   input  logic                  job_ready
);

   logic [2:0]  out_format_ff, out_format_in;
   logic        blend_enable_ff, blend_enable_in;
   logic [23:0] bg_narrow_ff, bg_narrow_in;
   logic [47:0] bg_wide_ff, bg_wide_in;
   logic [1:0]  red_slot_ff, red_slot_in;
   logic [1:0]  green_slot_ff, green_slot_in;
   logic [1:0]  blue_slot_ff, blue_slot_in;
   logic [2:0]  alpha_slot_ff, alpha_slot_in;

   logic          job_valid_ff, job_valid_in;
   pfcab_job_type job_ff, job_in;
   logic          take;

   always_comb begin
      out_format_in   = out_format_ff;
      blend_enable_in = blend_enable_ff;
      bg_narrow_in    = bg_narrow_ff;
      bg_wide_in      = bg_wide_ff;
      red_slot_in     = red_slot_ff;
      green_slot_in   = green_slot_ff;
      blue_slot_in    = blue_slot_ff;
      alpha_slot_in   = alpha_slot_ff;
      if (csr_we) begin
         case (csr_index)
            REG_OUT_FORMAT:        out_format_in   = csr_wdata[2:0];
            REG_BLEND_ENABLE:      blend_enable_in = csr_wdata[0];
            REG_BACKGROUND_NARROW: bg_narrow_in    = csr_wdata[23:0];
            REG_BACKGROUND_WIDE:   bg_wide_in      = csr_wdata[47:0];
            REG_RED_SLOT:          red_slot_in     = csr_wdata[1:0];
            REG_GREEN_SLOT:        green_slot_in   = csr_wdata[1:0];
            REG_BLUE_SLOT:         blue_slot_in    = csr_wdata[1:0];
            REG_ALPHA_SLOT:        alpha_slot_in   = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_format_ff   <= FMT_RGB24;
         blend_enable_ff <= 1'b0;
         bg_narrow_ff    <= '0;
         bg_wide_ff      <= '0;
         red_slot_ff     <= 2'd0;
         green_slot_ff   <= 2'd1;
         blue_slot_ff    <= 2'd2;
         alpha_slot_ff   <= 3'd3;
      end else begin
         out_format_ff   <= out_format_in;
         blend_enable_ff <= blend_enable_in;
         bg_narrow_ff    <= bg_narrow_in;
         bg_wide_ff      <= bg_wide_in;
         red_slot_ff     <= red_slot_in;
         green_slot_ff   <= green_slot_in;
         blue_slot_ff    <= blue_slot_in;
         alpha_slot_ff   <= alpha_slot_in;
      end
   end

   // classify the incoming word
   always_comb begin
      logic             wide;
      logic             out_wide;
      logic [15:0]      maxv;
      logic [15:0]      alpha;
      logic [2:0][15:0] comp;
      wide     = req_data.wide_components;
      out_wide = out_format_ff[0];
      maxv     = wide ? 16'hFFFF : 16'h00FF;
      alpha    = req_data.alpha_in & maxv;
      comp[0]  = req_data.red_in & maxv;
      comp[1]  = req_data.green_in & maxv;
      comp[2]  = req_data.blue_in & maxv;

      job_in.fmt_valid  = (out_format_ff <= FMT_RGBA64);
      job_in.gray       = (out_format_ff == FMT_GRAY8) || (out_format_ff == FMT_GRAY16);
      job_in.keep_alpha = (out_format_ff >= FMT_RGBA32) && (alpha_slot_ff < NO_ALPHA_SLOT);
      job_in.blend      = blend_enable_ff && (alpha < maxv) && !job_in.keep_alpha;
      job_in.wide_in    = wide;
      job_in.narrow_out = wide && !out_wide;
      job_in.alpha      = alpha;
      job_in.inv_alpha  = maxv - alpha;
      for (int ch = 0; ch < 3; ch++) begin
         if (!wide && !out_wide)
            job_in.bg[ch] = {8'd0, bg_narrow_ff[8*ch +: 8]};
         else
            job_in.bg[ch] = bg_wide_ff[16*ch +: 16];
         job_in.cw[ch] = (!wide && out_wide) ? {comp[ch][7:0], comp[ch][7:0]} : comp[ch];
      end
      if (wide && !out_wide)
         job_in.alpha_val = div257(alpha);
      else if (!wide && out_wide)
         job_in.alpha_val = {alpha[7:0], alpha[7:0]};
      else
         job_in.alpha_val = alpha;
      job_in.red_slot   = red_slot_ff;
      job_in.green_slot = green_slot_ff;
      job_in.blue_slot  = blue_slot_ff;
      job_in.alpha_slot = alpha_slot_ff[1:0];
   end

   assign busy = job_valid_ff && !job_ready;
   assign take = start && !busy;

   always_comb begin
      job_valid_in = job_valid_ff;
      if (!busy)
         job_valid_in = take;
   end

   always_ff @(posedge clock) begin
      if (reset)
         job_valid_ff <= 1'b0;
      else
         job_valid_ff <= job_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take)
         job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

[rtl/core/pfcab_queue.sv]
// Two-entry queue of classified pixels between front and back.
module pfcab_queue import pfcab_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pfcab_job_type push_job,
   output logic          push_ready,
   input  logic          pop,
   output logic          pop_valid,
   output pfcab_job_type pop_job
);

   pfcab_job_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[rtl/core/pfcab_back.sv]
// Back end: blend, width change, gray conversion and slot placement pipeline.
module pfcab_back import pfcab_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  pfcab_job_type in_job,
   output logic          rsp_valid,
   output pfcab_rsp_type rsp_data
);

   typedef struct packed {
      logic        fmt_valid;
      logic        gray;
      logic        keep_alpha;
      logic [15:0] alpha_val;
      logic [1:0]  red_slot;
      logic [1:0]  green_slot;
      logic [1:0]  blue_slot;
      logic [1:0]  alpha_slot;
   } place_type;

   // stage 1: blend products
   logic             s1_valid_ff;
   pfcab_job_type    s1_job_ff;
   logic [2:0][31:0] s1_pa_ff, s1_pa_in;
   logic [2:0][31:0] s1_pb_ff, s1_pb_in;

   // stage 2: blended and width-adjusted colors
   logic             s2_valid_ff;
   place_type        s2_place_ff, s2_place_in;
   logic [2:0][15:0] s2_val_ff, s2_val_in;

   // stage 3: gray products
   logic             s3_valid_ff;
   place_type        s3_place_ff;
   logic [2:0][15:0] s3_val_ff;
   logic [2:0][31:0] s3_gp_ff, s3_gp_in;

   // stage 4: output word
   logic             out_valid_ff;
   pfcab_rsp_type    out_ff, out_in;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         s1_pa_in[ch] = {16'd0, in_job.alpha} * {16'd0, in_job.cw[ch]};
         s1_pb_in[ch] = {16'd0, in_job.inv_alpha} * {16'd0, in_job.bg[ch]};
      end
   end

   always_comb begin
      logic [31:0] sum;
      logic [15:0] v;
      for (int ch = 0; ch < 3; ch++) begin
         sum = 32'({1'b0, s1_pa_ff[ch]} + {1'b0, s1_pb_ff[ch]});
         v   = s1_job_ff.blend ? div_by_max(sum, s1_job_ff.wide_in) : s1_job_ff.cw[ch];
         s2_val_in[ch] = s1_job_ff.narrow_out ? div257(v) : v;
      end
      s2_place_in.fmt_valid  = s1_job_ff.fmt_valid;
      s2_place_in.gray       = s1_job_ff.gray;
      s2_place_in.keep_alpha = s1_job_ff.keep_alpha;
      s2_place_in.alpha_val  = s1_job_ff.alpha_val;
      s2_place_in.red_slot   = s1_job_ff.red_slot;
      s2_place_in.green_slot = s1_job_ff.green_slot;
      s2_place_in.blue_slot  = s1_job_ff.blue_slot;
      s2_place_in.alpha_slot = s1_job_ff.alpha_slot;
   end

   always_comb begin
      s3_gp_in[0] = 32'd19595 * {16'd0, s2_val_ff[0]};
      s3_gp_in[1] = 32'd38470 * {16'd0, s2_val_ff[1]};
      s3_gp_in[2] = 32'd7471  * {16'd0, s2_val_ff[2]};
   end

   always_comb begin
      logic [31:0]      gsum;
      logic [3:0][15:0] slots;
      logic [3:0]       written;
      gsum    = 32'(s3_gp_ff[0] + s3_gp_ff[1] + s3_gp_ff[2]);
      slots   = '0;
      written = '0;
      if (s3_place_ff.fmt_valid) begin
         if (s3_place_ff.gray) begin
            slots[0]   = gsum[31:16];
            written[0] = 1'b1;
         end else begin
            // later writes win on colliding slots
            slots[s3_place_ff.red_slot]     = s3_val_ff[0];
            written[s3_place_ff.red_slot]   = 1'b1;
            slots[s3_place_ff.green_slot]   = s3_val_ff[1];
            written[s3_place_ff.green_slot] = 1'b1;
            slots[s3_place_ff.blue_slot]    = s3_val_ff[2];
            written[s3_place_ff.blue_slot]  = 1'b1;
            if (s3_place_ff.keep_alpha) begin
               slots[s3_place_ff.alpha_slot]   = s3_place_ff.alpha_val;
               written[s3_place_ff.alpha_slot] = 1'b1;
            end
         end
      end
      out_in.slot0        = slots[0];
      out_in.slot1        = slots[1];
      out_in.slot2        = slots[2];
      out_in.slot3        = slots[3];
      out_in.slot_written = written;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_job_ff <= in_job;
         s1_pa_ff  <= s1_pa_in;
         s1_pb_ff  <= s1_pb_in;
      end
      if (s1_valid_ff) begin
         s2_place_ff <= s2_place_in;
         s2_val_ff   <= s2_val_in;
      end
      if (s2_valid_ff) begin
         s3_place_ff <= s2_place_ff;
         s3_val_ff   <= s2_val_ff;
         s3_gp_ff    <= s3_gp_in;
      end
      if (s3_valid_ff)
         out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/core/pixel_format_convert_alpha_blend.sv]
// Top level of the pixel format converter with alpha blending.
//
// Converts one RGBA pixel word per clock. A word is taken at a rising edge
// where start is high and busy is low; its result appears on rsp_data for
// exactly one cycle, flagged by rsp_valid, after passing the front register,
// queue, blend multiply, blend divide and width change, gray multiply and slot
// placement registers. The receiver cannot hold results off, so the back pipeline
// drains one word every cycle; the front never finds the two-entry queue
// full, busy stays low, and a new word may be offered every clock.
// Configuration is written through csr_we/csr_index/csr_wdata, one register
// per cycle, and takes effect for words taken after the write; write only
// while no word is in flight.
module pixel_format_convert_alpha_blend import pfcab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  start,
   output logic                  busy,
   input  pfcab_req_type         req_data,
   output logic                  rsp_valid,
   output pfcab_rsp_type         rsp_data
);

   logic          front_valid;
   pfcab_job_type front_job;
   logic          queue_ready;
   logic          queue_valid;
   pfcab_job_type queue_job;

   // intake and classify; hold the word while the queue is full
   pfcab_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .job_valid (front_valid),
      .job       (front_job),
      .job_ready (queue_ready)
   );

   pfcab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_job   (front_job),
      .push_ready (queue_ready),
      .pop        (queue_valid),
      .pop_valid  (queue_valid),
      .pop_job    (queue_job)
   );

   // back pipeline never stalls: advance one word per cycle
   pfcab_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_job    (queue_job),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
